FILE: hdl/wsd_pkg.sv
package wsd_pkg;

    // Frame opcodes that the deframer accepts.
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // Header field masks and special length codes.
    localparam logic [7:0] RSV_MASK    = 8'h70;
    localparam logic [6:0] LEN_EXT16   = 7'h7E;
    localparam logic [6:0] LEN_EXT64   = 7'h7F;

    // Frame status codes reported with the last byte.
    localparam logic [1:0] ST_DATA  = 2'd0;
    localparam logic [1:0] ST_CLOSE = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // Byte position counter width and its saturation value.
    localparam int POS_W = 17;
    localparam logic [POS_W-1:0] POS_MAX = 17'h1FFFF;

    // One word of work handed from the parser to the output stage.
    typedef struct packed {
        logic       cand;    // byte lies in the payload of a clean text frame
        logic [7:0] data;    // unmasked byte, zero when cand is low
        logic       done;    // last byte of the frame
        logic [1:0] status;  // frame status, ST_DATA when done is low
    } t_work;

endpackage

FILE: hdl/wsd_front.sv
module wsd_front import wsd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_full,
    input  logic [7:0] i_data_byte,
    input  logic       i_frame_end,
    output logic       o_push,
    output t_work      o_work
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [3:0]       r_opcode, n_opcode;
    logic [15:0]      r_len, n_len;
    logic             r_ext, n_ext;
    logic [31:0]      r_key, n_key;
    logic             r_err, n_err;

    logic             accept;
    logic             text;
    logic [POS_W-1:0] hdr4;
    logic [POS_W-1:0] pay_end;
    logic             in_len;
    logic             in_key;
    logic             cand;
    logic [1:0]       key_sel;
    logic [7:0]       key_byte;
    logic [3:0]       upd_opcode;
    logic [15:0]      upd_len;
    logic             upd_ext;
    logic [31:0]      upd_key;
    logic             upd_err;
    logic             op_ok;
    logic [POS_W-1:0] upd_hdr;
    logic [POS_W-1:0] need;
    logic [POS_W:0]   count;
    logic             short_frame;
    logic [1:0]       status;

    assign accept = i_valid && !i_full;

    // Position decode for the current byte.
    assign text    = (r_opcode == OP_TEXT);
    assign hdr4    = r_ext ? POS_W'(8) : POS_W'(6);
    assign pay_end = hdr4 + {1'b0, r_len};
    assign in_len  = text && r_ext && (r_pos == POS_W'(2) || r_pos == POS_W'(3));
    assign in_key  = text && (r_pos >= POS_W'(2)) && (r_pos < hdr4) && !in_len;
    assign cand    = text && (r_pos >= hdr4) && (r_pos < pay_end) && !r_err;

    // Key byte for this payload byte: the payload index taken mod 4.
    assign key_sel = r_ext ? r_pos[1:0] : (r_pos[1:0] - 2'd2);

    always_comb begin
        case (key_sel)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    // Header parsing: opcode, length and key registers.
    always_comb begin
        upd_opcode = r_opcode;
        upd_len    = r_len;
        upd_ext    = r_ext;
        upd_key    = r_key;
        upd_err    = r_err;
        op_ok      = 1'b0;
        if (r_pos == '0) begin
            upd_opcode = i_data_byte[3:0];
            op_ok = (i_data_byte[3:0] == OP_TEXT) || (i_data_byte[3:0] == OP_BINARY) ||
                    (i_data_byte[3:0] == OP_CLOSE) || (i_data_byte[3:0] == OP_PING) ||
                    (i_data_byte[3:0] == OP_PONG);
            if ((i_data_byte & RSV_MASK) != 8'h00 || !i_data_byte[7] || !op_ok) begin
                upd_err = 1'b1;
            end
        end else if (r_pos == POS_W'(1)) begin
            if (!i_data_byte[7]) begin
                upd_err = 1'b1;
            end
            if (text) begin
                if (i_data_byte[6:0] == LEN_EXT16) begin
                    upd_ext = 1'b1;
                    upd_len = 16'h0000;
                end else if (i_data_byte[6:0] == LEN_EXT64) begin
                    upd_err = 1'b1;
                    upd_len = 16'h0000;
                end else begin
                    upd_len = {9'h000, i_data_byte[6:0]};
                end
            end
        end else if (in_len) begin
            upd_len = {r_len[7:0], i_data_byte};
        end else if (in_key) begin
            upd_key = {r_key[23:0], i_data_byte};
        end
    end

    // Frame length check and final status on the last byte.
    always_comb begin
        upd_hdr = upd_ext ? POS_W'(4) : POS_W'(2);
        if (text) begin
            need = (upd_len != 16'h0000) ? (upd_hdr + POS_W'(4) + {1'b0, upd_len}) : upd_hdr;
        end else begin
            need = POS_W'(2);
        end
        count       = {1'b0, r_pos} + (POS_W+1)'(1);
        short_frame = (count < {1'b0, need});
        if (upd_err || short_frame) begin
            status = ST_ERROR;
        end else if (upd_opcode == OP_CLOSE) begin
            status = ST_CLOSE;
        end else begin
            status = ST_DATA;
        end
    end

    // Next state: everything clears after the last byte of a frame.
    always_comb begin
        if (i_frame_end) begin
            n_pos    = '0;
            n_opcode = 4'h0;
            n_len    = 16'h0000;
            n_ext    = 1'b0;
            n_key    = 32'h0;
            n_err    = 1'b0;
        end else begin
            n_pos    = (r_pos != POS_MAX) ? (r_pos + POS_W'(1)) : r_pos;
            n_opcode = upd_opcode;
            n_len    = upd_len;
            n_ext    = upd_ext;
            n_key    = upd_key;
            n_err    = upd_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_opcode <= 4'h0;
            r_len    <= 16'h0000;
            r_ext    <= 1'b0;
            r_key    <= 32'h0;
            r_err    <= 1'b0;
        end else if (accept) begin
            r_pos    <= n_pos;
            r_opcode <= n_opcode;
            r_len    <= n_len;
            r_ext    <= n_ext;
            r_key    <= n_key;
            r_err    <= n_err;
        end
    end

    // Only payload candidates and frame ends go on to the output stage.
    assign o_push        = accept && (cand || i_frame_end);
    assign o_work.cand   = cand;
    assign o_work.data   = cand ? (i_data_byte ^ key_byte) : 8'h00;
    assign o_work.done   = i_frame_end;
    assign o_work.status = i_frame_end ? status : ST_DATA;

endmodule

FILE: hdl/wsd_queue.sv
module wsd_queue import wsd_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_work,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_nonempty,
    output t_work o_work
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_work           r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_cnt, n_cnt;

    assign o_full     = (r_cnt == CW'(DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_work     = r_mem[r_rd];

    // Pointer and fill count update.
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : (r_wr + AW'(1));
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : (r_rd + AW'(1));
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Storage words carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_work;
        end
    end

endmodule

FILE: hdl/wsd_back.sv
module wsd_back import wsd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_nonempty,
    input  t_work      i_work,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_byte_valid,
    output logic [7:0] o_payload_byte,
    output logic       o_frame_done,
    output logic [1:0] o_frame_status
);

    logic       r_out_valid;
    logic       r_zero;
    logic       r_byte_valid;
    logic [7:0] r_payload;
    logic       r_done;
    logic [1:0] r_status;
    logic       emit;

    // Take a word whenever the output register is free or being drained.
    assign o_pop = i_nonempty && (!r_out_valid || !i_out_stall);

    // A zero unmasked byte ends the text for the rest of the frame.
    assign emit = i_work.cand && (i_work.data != 8'h00) && !r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_zero      <= 1'b0;
        end else begin
            if (o_pop) begin
                r_out_valid <= emit || i_work.done;
                if (i_work.done) begin
                    r_zero <= 1'b0;
                end else if (i_work.cand && i_work.data == 8'h00) begin
                    r_zero <= 1'b1;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_byte_valid <= emit;
            r_payload    <= emit ? i_work.data : 8'h00;
            r_done       <= i_work.done;
            r_status     <= i_work.status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_byte_valid   = r_byte_valid;
    assign o_payload_byte = r_payload;
    assign o_frame_done   = r_done;
    assign o_frame_status = r_status;

endmodule

FILE: hdl/websocket_frame_deframer_top.sv
// A word accepted at the input is written into the queue, then into the output register.
// Throughput: one byte per cycle unless the queue is full; the parser and the output stage
// run in step, with a small queue between them that absorbs output stalls.
// Header, key and non-text or bad-frame bytes enter the queue only when they end a frame.
// Reset is synchronous and active low; it clears the parser, queue and output valid.
module websocket_frame_deframer_top import wsd_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_frame_end,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_byte_valid,
    output logic [7:0] o_payload_byte,
    output logic       o_frame_done,
    output logic [1:0] o_frame_status
);

    logic  push;
    logic  pop;
    logic  full;
    logic  nonempty;
    t_work push_work;
    t_work head_work;

    assign o_in_stall = full;

    // Header parser and unmasking.
    wsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_full      (full),
        .i_data_byte (i_data_byte),
        .i_frame_end (i_frame_end),
        .o_push      (push),
        .o_work      (push_work)
    );

    // Queue between parser and output stage.
    wsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_work     (push_work),
        .i_pop      (pop),
        .o_full     (full),
        .o_nonempty (nonempty),
        .o_work     (head_work)
    );

    // Zero-byte stop and result register.
    wsd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_nonempty     (nonempty),
        .i_work         (head_work),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_byte_valid   (o_byte_valid),
        .o_payload_byte (o_payload_byte),
        .o_frame_done   (o_frame_done),
        .o_frame_status (o_frame_status)
    );

`ifndef SYNTHESIS
    // Every result word carries a text byte, a frame end, or both.
    a_word_has_content: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_byte_valid || o_frame_done))
        else $error("result word with neither byte nor frame end");

    // An emitted text byte is never the zero terminator.
    a_no_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_byte_valid) |-> (o_payload_byte != 8'h00))
        else $error("zero byte emitted");

    // Status is only reported with a frame end and is never an undefined code.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_frame_done ? (o_frame_status != 2'd3)
                                      : (o_frame_status == ST_DATA)))
        else $error("bad frame status");

    // The parser never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("queue overflow");
`endif

endmodule

FILE: verif/websocket_frame_deframer_checker.sv
module websocket_frame_deframer_checker import wsd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_frame_end,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic       i_byte_valid,
    input  logic [7:0] i_payload_byte,
    input  logic       i_frame_done,
    input  logic [1:0] i_frame_status,
    output int         o_mismatches,
    output int         o_pending,
    output int         o_words_checked
);

    // One output word as the deframer presents it.
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] payload;
        logic       done;
        logic [1:0] status;
    } deframe_word_t;

    // Parser state of the frame in progress, cleared after every last byte.
    logic [POS_W-1:0] pos_q;
    logic [3:0]       opcode_q;
    logic [15:0]      length_q;
    logic             ext_q;
    logic [31:0]      key_q;
    logic             err_q;
    logic             zero_q;

    deframe_word_t expected_words[$];

    // Advances the parser by one byte and queues the word it should produce, if any.
    task automatic deframe_byte(input logic [7:0] b, input logic last);
        int unsigned   pos;
        int unsigned   hdr;
        int unsigned   idx;
        int unsigned   need;
        int unsigned   sel;
        logic          is_text;
        logic [7:0]    plain;
        deframe_word_t w;
        pos     = pos_q;
        hdr     = ext_q ? 4 : 2;
        is_text = (opcode_q == OP_TEXT);
        w       = '0;

        if (pos == 0) begin
            // First byte: FIN, reserved bits and opcode.
            opcode_q = b[3:0];
            if ((b & RSV_MASK) != 8'h00 || !b[7]) begin
                err_q = 1'b1;
            end
            case (b[3:0])
                OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG: ;
                default: err_q = 1'b1;
            endcase
        end else if (pos == 1) begin
            // Second byte: mask bit and the short length code.
            if (!b[7]) begin
                err_q = 1'b1;
            end
            if (is_text) begin
                if (b[6:0] == LEN_EXT16) begin
                    ext_q    = 1'b1;
                    length_q = '0;
                end else if (b[6:0] == LEN_EXT64) begin
                    err_q    = 1'b1;
                    length_q = '0;
                end else begin
                    length_q = {9'd0, b[6:0]};
                end
            end
        end else if (is_text) begin
            if (ext_q && pos < 4) begin
                length_q = {length_q[7:0], b};
            end else if (pos < hdr + 4) begin
                key_q = {key_q[23:0], b};
            end else begin
                // Payload: unmask while inside the length and nothing has stopped output.
                idx = pos - hdr - 4;
                if (idx < length_q && !err_q && !zero_q) begin
                    sel   = 3 - (idx % 4);
                    plain = b ^ key_q[sel*8 +: 8];
                    if (plain == 8'h00) begin
                        zero_q = 1'b1;
                    end else begin
                        w.byte_valid = 1'b1;
                        w.payload    = plain;
                    end
                end
            end
        end

        if (pos_q != POS_MAX) begin
            pos_q = pos_q + 1'b1;
        end

        // Last byte: decide the status and start over.
        if (last) begin
            need = 2;
            if (is_text) begin
                need = ext_q ? 4 : 2;
                if (length_q != 0) begin
                    need = need + 4 + length_q;
                end
            end
            w.done = 1'b1;
            if (err_q || pos + 1 < need) begin
                w.status = ST_ERROR;
            end else if (opcode_q == OP_CLOSE) begin
                w.status = ST_CLOSE;
            end else begin
                w.status = ST_DATA;
            end
            pos_q    = '0;
            opcode_q = '0;
            length_q = '0;
            ext_q    = 1'b0;
            key_q    = '0;
            err_q    = 1'b0;
            zero_q   = 1'b0;
        end

        if (w.byte_valid || w.done) begin
            expected_words.push_back(w);
        end
    endtask

    // Predict on every accepted input word, then compare every accepted output word.
    always @(posedge i_clk) begin : watch
        deframe_word_t got;
        deframe_word_t want;
        if (!i_rst_n) begin
            pos_q    = '0;
            opcode_q = '0;
            length_q = '0;
            ext_q    = 1'b0;
            key_q    = '0;
            err_q    = 1'b0;
            zero_q   = 1'b0;
            expected_words.delete();
            o_mismatches    <= 0;
            o_pending       <= 0;
            o_words_checked <= 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                deframe_byte(i_data_byte, i_frame_end);
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_byte_valid, i_payload_byte, i_frame_done, i_frame_status};
                o_words_checked <= o_words_checked + 1;
                if (expected_words.size() == 0) begin
                    if (o_mismatches < 10) begin
                        $display("ERROR %0t: unexpected word valid=%0b byte=%02h done=%0b status=%0d",
                                 $time, got.byte_valid, got.payload, got.done, got.status);
                    end
                    o_mismatches <= o_mismatches + 1;
                end else begin
                    want = expected_words.pop_front();
                    if (got.byte_valid !== want.byte_valid || got.payload !== want.payload ||
                        got.done !== want.done || got.status !== want.status) begin
                        if (o_mismatches < 10) begin
                            $display("ERROR %0t: expected valid=%0b byte=%02h done=%0b status=%0d",
                                     $time, want.byte_valid, want.payload, want.done, want.status);
                            $display("       %0t:      got valid=%0b byte=%02h done=%0b status=%0d",
                                     $time, got.byte_valid, got.payload, got.done, got.status);
                        end
                        o_mismatches <= o_mismatches + 1;
                    end
                end
            end
            o_pending <= expected_words.size();
        end
    end

endmodule

FILE: verif/tb_websocket_frame_deframer_top.sv
module tb_websocket_frame_deframer_top;
    import wsd_pkg::*;

    localparam int          IDLE_MAX   = 19;
    localparam int          ITEM_COUNT = 2000;
    localparam logic [3:0]  OP_UNDEFINED = 4'h3;
    localparam logic [7:0]  HDR_TEXT  = {1'b1, 3'b000, OP_TEXT};
    localparam logic [7:0]  HDR_CLOSE = {1'b1, 3'b000, OP_CLOSE};
    localparam logic [7:0]  MASK_BIT  = 8'h80;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic [7:0] i_data_byte  = 8'h00;
    logic       i_frame_end  = 1'b0;
    logic       i_out_stall  = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_byte_valid;
    logic [7:0] o_payload_byte;
    logic       o_frame_done;
    logic [1:0] o_frame_status;

    int          mismatch_count;
    int          pending_words;
    int          words_checked;
    int unsigned bytes_sent  = 0;
    int unsigned frames_sent = 0;
    int unsigned stall_left  = 0;
    logic        tx_quiet    = 1'b0;
    logic        rx_quiet    = 1'b0;
    logic [7:0]  frame_bytes[$];

    websocket_frame_deframer_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_frame_end    (i_frame_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_byte_valid   (o_byte_valid),
        .o_payload_byte (o_payload_byte),
        .o_frame_done   (o_frame_done),
        .o_frame_status (o_frame_status)
    );

    websocket_frame_deframer_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_frame_end     (i_frame_end),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_byte_valid    (o_byte_valid),
        .i_payload_byte  (o_payload_byte),
        .i_frame_done    (o_frame_done),
        .i_frame_status  (o_frame_status),
        .o_mismatches    (mismatch_count),
        .o_pending       (pending_words),
        .o_words_checked (words_checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Output side: after each word taken, stall for a random number of cycles.
    always @(posedge i_clk) begin : out_side
        int unsigned hold;
        if (!i_rst_n) begin
            stall_left  <= 0;
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                hold = rx_quiet ? 0 : $urandom_range(0, IDLE_MAX);
                if ($urandom_range(0, 39) == 0) begin
                    rx_quiet <= !rx_quiet;
                end
            end else begin
                hold = (stall_left != 0) ? stall_left - 1 : 0;
            end
            stall_left  <= hold;
            i_out_stall <= (hold != 0);
        end
    end

    // Presents one word after a random gap and holds it until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_frame_end <= last;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
        if (last) begin
            frames_sent++;
        end
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_bytes.size(); i++) begin
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
    endtask

    // Holds the input idle until every predicted word has come out.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
    endtask

    // Mostly well-formed frames with random content; some corrupted, cut short or pure noise.
    task automatic build_random_frame(output int unsigned useful);
        int unsigned kind;
        int unsigned len;
        int unsigned cut;
        int unsigned i;
        logic [7:0]  key[4];
        logic [3:0]  op;
        logic [7:0]  head;
        frame_bytes.delete();
        kind = $urandom_range(0, 99);
        for (i = 0; i < 4; i++) begin
            key[i] = 8'($urandom_range(0, 255));
        end
        if (kind >= 90) begin
            repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom_range(0, 255)));
            useful = frame_bytes.size();
        end else begin
            if (kind < 60 || kind >= 85) begin
                op  = OP_TEXT;
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 300)
                                                   : $urandom_range(0, 24);
            end else begin
                case ($urandom_range(0, 3))
                    0:       op = OP_BINARY;
                    1:       op = OP_CLOSE;
                    2:       op = OP_PING;
                    default: op = OP_PONG;
                endcase
                len = $urandom_range(0, 12);
            end
            frame_bytes.push_back({1'b1, 3'b000, op});
            if (len > 125 || (op == OP_TEXT && $urandom_range(0, 9) == 0)) begin
                frame_bytes.push_back({1'b1, LEN_EXT16});
                frame_bytes.push_back(len[15:8]);
                frame_bytes.push_back(len[7:0]);
            end else begin
                frame_bytes.push_back({1'b1, len[6:0]});
            end
            if (len != 0 || $urandom_range(0, 1) == 1) begin
                for (i = 0; i < 4; i++) frame_bytes.push_back(key[i]);
            end
            // Now and then a raw byte equal to its key byte, which unmasks to zero.
            for (i = 0; i < len; i++) begin
                frame_bytes.push_back(($urandom_range(0, 19) == 0) ? key[i % 4]
                                                                   : 8'($urandom_range(0, 255)));
            end

            if (kind >= 80) begin
                head = frame_bytes[0];
                case ($urandom_range(0, 4))
                    0: head[6:4] = 3'($urandom_range(1, 7));
                    1: head[7]   = 1'b0;
                    2: begin
                        head = frame_bytes[1];
                        head[7] = 1'b0;
                        frame_bytes[1] = head;
                        head = frame_bytes[0];
                    end
                    3: begin
                        do op = 4'($urandom_range(0, 15));
                        while (op == OP_TEXT || op == OP_BINARY || op == OP_CLOSE ||
                               op == OP_PING || op == OP_PONG);
                        head[3:0] = op;
                    end
                    default: begin
                        head = frame_bytes[1];
                        head[6:0] = LEN_EXT64;
                        frame_bytes[1] = head;
                        head = frame_bytes[0];
                    end
                endcase
                frame_bytes[0] = head;
            end

            // Payload of non-text frames is skipped by the block, so only the header counts.
            useful = (op == OP_TEXT || kind >= 80) ? frame_bytes.size() : 2;
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end

        if ($urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, frame_bytes.size());
            while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
            if (useful > cut) begin
                useful = cut;
            end
        end
    endtask

    initial begin
        #10_000_000;
        $display("websocket_frame_deframer_top regression: fail");
        $finish;
    end

    initial begin : stimulus
        int unsigned useful;
        int unsigned items_done;
        logic        pressure_done;
        items_done    = 0;
        pressure_done = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Text frame with extreme bytes, a zero byte that stops output, and a trailing byte.
        frame_bytes = '{HDR_TEXT, MASK_BIT | 8'd5, 8'hFF, 8'h00, 8'hA5, 8'h5A,
                        8'h00, 8'hFF, 8'hA4, 8'h5A, 8'h77, 8'h33};
        send_frame();
        // Clean close, and a close with FIN clear where the error wins.
        frame_bytes = '{HDR_CLOSE, MASK_BIT};
        send_frame();
        frame_bytes = '{HDR_CLOSE & 8'h7F, MASK_BIT};
        send_frame();
        // Frame of a single byte.
        frame_bytes = '{HDR_TEXT};
        send_frame();
        // 64-bit length code, reserved bits, unknown opcode, mask bit clear.
        frame_bytes = '{HDR_TEXT, {1'b1, LEN_EXT64}};
        send_frame();
        frame_bytes = '{HDR_TEXT | RSV_MASK, MASK_BIT};
        send_frame();
        frame_bytes = '{{1'b1, 3'b000, OP_UNDEFINED}, MASK_BIT};
        send_frame();
        frame_bytes = '{HDR_TEXT, 8'h00};
        send_frame();
        // Largest 16-bit length, cut off right after the length bytes.
        frame_bytes = '{HDR_TEXT, {1'b1, LEN_EXT16}, 8'hFF, 8'hFF};
        send_frame();
        wait_for_results();

        // Random frames, with quiet stretches on the input side now and then.
        while (items_done < ITEM_COUNT) begin
            build_random_frame(useful);
            send_frame();
            items_done += useful;
            if ($urandom_range(0, 9) == 0) begin
                tx_quiet = !tx_quiet;
            end
            if (!pressure_done && items_done >= ITEM_COUNT / 2) begin
                wait_for_results();
                pressure_done = 1'b1;
            end
        end

        wait_for_results();
        repeat (10) @(posedge i_clk);

        $display("Drove %0d bytes in %0d frames: directed headers and errors, then random frames",
                 bytes_sent, frames_sent);
        $display("under random stalls; %0d output words checked, %0d mismatches.",
                 words_checked, mismatch_count);
        if (mismatch_count == 0 && pending_words == 0) begin
            $display("websocket_frame_deframer_top regression: pass");
        end else begin
            $display("websocket_frame_deframer_top regression: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/wsd_pkg.sv
hdl/wsd_front.sv
hdl/wsd_queue.sv
hdl/wsd_back.sv
hdl/websocket_frame_deframer_top.sv
verif/websocket_frame_deframer_checker.sv
verif/tb_websocket_frame_deframer_top.sv
